[rtl/hcbd_pkg.sv]
// Shared constants, types and helpers for the chunked body decoder.
`timescale 1ns / 1ps

package hcbd_pkg;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_FF    = 8'h0C;

    typedef enum logic [1:0] {
        ST_BUSY = 2'd0,
        ST_DONE = 2'd1,
        ST_ERR  = 2'd2
    } t_status;

    // Size line flags handed from the parser to the top level.
    typedef struct packed {
        logic to_cr;         // byte was CR, line may end
        logic overflow;      // digit would overflow the size
        logic digit_seen;
        logic digits_ended;
    } t_size_flags;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

[rtl/http_chunked_body_decoder.sv]
// Top level of the HTTP/1.1 chunked transfer body decoder.
`timescale 1ns / 1ps
// An accepted word's result is registered and shows in the cycle after it is taken.
// Throughput: 1 word per cycle while the receiver takes every result.
// Input is ready when the output register is empty or drained in the same cycle,
//   so a result the receiver holds back stalls the input.
// Reset (i_rst_n low, synchronous): size line phase, size 0, trailer line empty,
//   output register empty. Complete and error hold until the next reset.

module http_chunked_body_decoder #(
    parameter int SIZE_BITS = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [7:0]          i_in_byte,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [7:0]          o_data_byte,
    output logic                o_data_valid,
    output logic                o_chunk_last,
    output logic [1:0]          o_status
);
    import hcbd_pkg::*;

    typedef enum logic [3:0] {
        PH_SIZE       = 4'd0,
        PH_SIZE_CR    = 4'd1,
        PH_DATA       = 4'd2,
        PH_DATA_CR    = 4'd3,
        PH_DATA_LF    = 4'd4,
        PH_TRAILER    = 4'd5,
        PH_TRAILER_CR = 4'd6,
        PH_COMPLETE   = 4'd7,
        PH_ERROR      = 4'd8
    } t_phase;

    t_phase               r_phase, n_phase;
    logic [SIZE_BITS-1:0] r_remain, n_remain;
    logic                 r_digit_seen, n_digit_seen;
    logic                 r_digits_ended, n_digits_ended;
    logic                 r_line_empty, n_line_empty;

    logic                 r_out_valid;
    logic [7:0]           r_data_byte, n_data_byte;
    logic                 r_data_valid, n_data_valid;
    logic                 r_chunk_last, n_chunk_last;
    t_status              r_status, n_status;

    logic                 accept;
    logic [SIZE_BITS-1:0] sp_size;
    t_size_flags          sp_flags;
    logic                 sp_ended_in;
    logic [SIZE_BITS-1:0] remain_dec;

    // Ready whenever the result slot is empty or being drained this cycle.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    // A CR not followed by LF after digits ends the digits.
    assign sp_ended_in = r_digits_ended || ((r_phase == PH_SIZE_CR) && r_digit_seen);
    assign remain_dec  = r_remain - SIZE_BITS'(1);

    hcbd_size_line #(
        .SIZE_BITS (SIZE_BITS)
    ) u_size_line (
        .i_byte         (i_in_byte),
        .i_size         (r_remain),
        .i_digit_seen   (r_digit_seen),
        .i_digits_ended (sp_ended_in),
        .o_size         (sp_size),
        .o_flags        (sp_flags)
    );

    always_comb begin
        n_phase        = r_phase;
        n_remain       = r_remain;
        n_digit_seen   = r_digit_seen;
        n_digits_ended = r_digits_ended;
        n_line_empty   = r_line_empty;
        n_data_byte    = 8'd0;
        n_data_valid   = 1'b0;
        n_chunk_last   = 1'b0;

        unique case (r_phase)
            PH_SIZE, PH_SIZE_CR: begin
                if (r_phase == PH_SIZE_CR && i_in_byte == CHAR_LF) begin
                    if (!r_digit_seen) begin
                        n_phase = PH_ERROR;
                    end else if (r_remain == '0) begin
                        n_phase      = PH_TRAILER;
                        n_line_empty = 1'b1;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end else begin
                    // ordinary size line text
                    n_remain       = sp_size;
                    n_digit_seen   = sp_flags.digit_seen;
                    n_digits_ended = sp_flags.digits_ended;
                    if (sp_flags.overflow) begin
                        n_phase = PH_ERROR;
                    end else if (sp_flags.to_cr) begin
                        n_phase = PH_SIZE_CR;
                    end else begin
                        n_phase = PH_SIZE;
                    end
                end
            end
            PH_DATA: begin
                n_data_byte  = i_in_byte;
                n_data_valid = 1'b1;
                n_remain     = remain_dec;
                if (remain_dec == '0) begin
                    n_chunk_last = 1'b1;
                    n_phase      = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                n_phase = (i_in_byte == CHAR_CR) ? PH_DATA_LF : PH_ERROR;
            end
            PH_DATA_LF: begin
                if (i_in_byte == CHAR_LF) begin
                    n_phase        = PH_SIZE;
                    n_remain       = '0;
                    n_digit_seen   = 1'b0;
                    n_digits_ended = 1'b0;
                end else begin
                    n_phase = PH_ERROR;
                end
            end
            PH_TRAILER: begin
                if (i_in_byte == CHAR_CR) begin
                    n_phase = PH_TRAILER_CR;
                end else begin
                    n_line_empty = 1'b0;
                end
            end
            PH_TRAILER_CR: begin
                if (i_in_byte == CHAR_LF) begin
                    if (r_line_empty) begin
                        n_phase = PH_COMPLETE;
                    end else begin
                        n_line_empty = 1'b1;
                        n_phase      = PH_TRAILER;
                    end
                end else if (i_in_byte == CHAR_CR) begin
                    n_line_empty = 1'b0;    // lone CR counts as trailer text
                end else begin
                    n_line_empty = 1'b0;
                    n_phase      = PH_TRAILER;
                end
            end
            PH_COMPLETE: begin
                // body done, bytes ignored
            end
            default: begin
                n_phase = PH_ERROR;
            end
        endcase

        if (n_phase == PH_COMPLETE) begin
            n_status = ST_DONE;
        end else if (n_phase == PH_ERROR) begin
            n_status = ST_ERR;
        end else begin
            n_status = ST_BUSY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SIZE;
            r_remain       <= '0;
            r_digit_seen   <= 1'b0;
            r_digits_ended <= 1'b0;
            r_line_empty   <= 1'b1;
            r_out_valid    <= 1'b0;
        end else begin
            if (accept) begin
                r_phase        <= n_phase;
                r_remain       <= n_remain;
                r_digit_seen   <= n_digit_seen;
                r_digits_ended <= n_digits_ended;
                r_line_empty   <= n_line_empty;
                r_out_valid    <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload, loaded on accept only
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_data_byte  <= n_data_byte;
            r_data_valid <= n_data_valid;
            r_chunk_last <= n_chunk_last;
            r_status     <= n_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_data_byte  = r_data_byte;
    assign o_data_valid = r_data_valid;
    assign o_chunk_last = r_chunk_last;
    assign o_status     = r_status;

`ifndef SYNTHESIS
    a_error_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_ERROR |=> r_phase == PH_ERROR)
        else $error("error phase left before reset");

    a_complete_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_COMPLETE |=> r_phase == PH_COMPLETE)
        else $error("complete phase left before reset");

    a_last_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_chunk_last |-> o_data_valid && o_status == ST_BUSY)
        else $error("chunk_last without payload byte");

    a_idle_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_data_valid |-> o_data_byte == 8'd0)
        else $error("nonzero data byte on non-payload word");

    a_data_needs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DATA |-> r_remain != '0)
        else $error("payload phase with zero bytes due");
`endif

endmodule

[rtl/hcbd_size_line.sv]
// Size line byte parser: hex accumulate, blank skip, extension skip.
`timescale 1ns / 1ps

module hcbd_size_line #(
    parameter int SIZE_BITS = 32
) (
    input  logic [7:0]                 i_byte,
    input  logic [SIZE_BITS-1:0]       i_size,
    input  logic                       i_digit_seen,
    input  logic                       i_digits_ended,
    output logic [SIZE_BITS-1:0]       o_size,
    output hcbd_pkg::t_size_flags      o_flags
);
    import hcbd_pkg::*;

    t_hex hx;
    logic is_blank;

    assign hx       = hex_decode(i_byte);
    assign is_blank = (i_byte == CHAR_SPACE) || (i_byte >= CHAR_TAB && i_byte <= CHAR_FF);

    always_comb begin
        o_size                = i_size;
        o_flags.to_cr         = 1'b0;
        o_flags.overflow      = 1'b0;
        o_flags.digit_seen    = i_digit_seen;
        o_flags.digits_ended  = i_digits_ended;
        if (i_byte == CHAR_CR) begin
            o_flags.to_cr = 1'b1;
        end else if (i_digits_ended) begin
            // extension text, ignored
        end else if (hx.is_hex) begin
            if (i_size[SIZE_BITS-1 -: 4] != 4'd0) begin
                o_flags.overflow = 1'b1;
            end else begin
                o_size             = {i_size[SIZE_BITS-5:0], hx.value};
                o_flags.digit_seen = 1'b1;
            end
        end else if (!(is_blank && !i_digit_seen)) begin
            o_flags.digits_ended = 1'b1;
        end
    end

endmodule

[tb/sv/tb_http_chunked_body_decoder.sv]
// Testbench for the chunked body decoder: a random chunked body checked word by word.
`timescale 1ns / 1ps

module tb_http_chunked_body_decoder;
    import hcbd_pkg::*;

    localparam int SIZE_BITS    = 32;
    localparam int MAX_GAP      = 5;      // bound on the random per-word idle gap on either side
    localparam int HOLD_CYCLES  = 200;    // long receiver hold-off, fills the output stage
    localparam int TARGET_BYTES = 1850;
    localparam int DRAIN_LIMIT  = 10000;
    localparam int SETTLE       = 4;      // margin after the prediction queue drains

    localparam logic [7:0] CHAR_VT   = 8'h0B;
    localparam logic [7:0] CHAR_SEMI = 8'h3B;
    localparam logic [7:0] CHAR_X    = 8'h78;

    // Decoder phases, mirrored from the byte-level behavior.
    typedef enum logic [3:0] {
        PH_SIZE, PH_SIZE_CR, PH_DATA, PH_DATA_CR, PH_DATA_LF,
        PH_TRAILER, PH_TRAILER_CR, PH_COMPLETE, PH_ERROR
    } t_phase;

    // How the single body of the run is closed. Complete and error are sticky
    // and reset comes only once, so each run ends its body one of these ways.
    typedef enum int {
        END_COMPLETE, END_NO_DIGITS, END_OVERFLOW, END_NO_CR, END_NO_LF, END_OPEN_DATA
    } t_body_end;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       data_valid;
        logic       chunk_last;
        t_status    status;
    } t_decoded;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic [7:0] i_in_byte   = 8'h00;
    logic       i_out_ready = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    logic [7:0] o_data_byte;
    logic       o_data_valid;
    logic       o_chunk_last;
    logic [1:0] o_status;

    http_chunked_body_decoder #(
        .SIZE_BITS(SIZE_BITS)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_byte   (i_in_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_data_byte (o_data_byte),
        .o_data_valid(o_data_valid),
        .o_chunk_last(o_chunk_last),
        .o_status    (o_status)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Decoder prediction state
    // ---------------------------------------------------------------
    t_phase               phase_q;
    logic [SIZE_BITS-1:0] size_left;     // size being parsed, then payload bytes still due
    bit                   digit_seen;
    bit                   digits_ended;
    bit                   line_empty;    // current trailer line has no text yet

    t_decoded predicted_words[$];

    // Run bookkeeping
    bit        gaps_on      = 1'b1;   // off for back-to-back stretches
    int        hold_request = 0;      // set by a test, picked up by the receiver
    int        hold_left    = 0;
    int        stall_left   = 0;
    int        bytes_sent   = 0;
    int        chunks_sent  = 0;
    int        payload_sent = 0;
    int        words_checked = 0;
    int        mismatches   = 0;
    t_body_end end_kind     = END_COMPLETE;

    function automatic int hex_value(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        return -1;
    endfunction

    function automatic void clear_size_line();
        phase_q      = PH_SIZE;
        size_left    = '0;
        digit_seen   = 1'b0;
        digits_ended = 1'b0;
    endfunction

    // One size line byte other than a line-ending CR LF.
    function automatic void take_size_char(input logic [7:0] c);
        int v;
        v = hex_value(c);
        if (c == CHAR_CR) begin
            phase_q = PH_SIZE_CR;
        end else if (!digits_ended) begin
            if (v >= 0) begin
                // Overflow: the shift would push a set nibble out of the top.
                if (size_left[SIZE_BITS-1 -: 4] != 4'd0) begin
                    phase_q = PH_ERROR;
                end else begin
                    size_left  = {size_left[SIZE_BITS-5:0], 4'(v)};
                    digit_seen = 1'b1;
                end
            end else if (digit_seen || !(c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_FF))) begin
                // Blanks before the first digit are skipped; anything else ends the digits.
                digits_ended = 1'b1;
            end
        end
    endfunction

    // Advances the prediction by one accepted byte and returns its result word.
    function automatic t_decoded predict_decode(input logic [7:0] c);
        t_decoded r;
        r = '0;
        case (phase_q)
            PH_SIZE: begin
                take_size_char(c);
            end
            PH_SIZE_CR: begin
                if (c == CHAR_LF) begin
                    if (!digit_seen) begin
                        phase_q = PH_ERROR;
                    end else if (size_left == '0) begin
                        phase_q    = PH_TRAILER;
                        line_empty = 1'b1;
                    end else begin
                        phase_q = PH_DATA;
                    end
                end else begin
                    // The CR was plain text of the line.
                    if (digit_seen) digits_ended = 1'b1;
                    phase_q = PH_SIZE;
                    take_size_char(c);
                end
            end
            PH_DATA: begin
                r.data_byte  = c;
                r.data_valid = 1'b1;
                size_left    = size_left - 1'b1;
                if (size_left == '0) begin
                    r.chunk_last = 1'b1;
                    phase_q      = PH_DATA_CR;
                end
            end
            PH_DATA_CR: begin
                phase_q = (c == CHAR_CR) ? PH_DATA_LF : PH_ERROR;
            end
            PH_DATA_LF: begin
                if (c == CHAR_LF) clear_size_line();
                else phase_q = PH_ERROR;
            end
            PH_TRAILER: begin
                if (c == CHAR_CR) phase_q = PH_TRAILER_CR;
                else line_empty = 1'b0;
            end
            PH_TRAILER_CR: begin
                if (c == CHAR_LF) begin
                    if (line_empty) begin
                        phase_q = PH_COMPLETE;
                    end else begin
                        line_empty = 1'b1;
                        phase_q    = PH_TRAILER;
                    end
                end else if (c == CHAR_CR) begin
                    line_empty = 1'b0;
                end else begin
                    line_empty = 1'b0;
                    phase_q    = PH_TRAILER;
                end
            end
            PH_COMPLETE: begin
            end
            default: begin
                phase_q = PH_ERROR;
            end
        endcase
        r.status = (phase_q == PH_COMPLETE) ? ST_DONE :
                   (phase_q == PH_ERROR)    ? ST_ERR  : ST_BUSY;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Input side: one word per call. Valid is left high on return so the
    // next call can present its word in the same step without a drop.
    // ---------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_byte  <= b;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        predicted_words.push_back(predict_decode(b));
        bytes_sent++;
    endtask

    function automatic logic [7:0] hex_char(input int v);
        if (v < 10) return 8'(int'("0") + v);
        return 8'(($urandom_range(0, 1) ? int'("A") : int'("a")) + v - 10);
    endfunction

    // Free text for extensions and trailer lines; a CR is always followed by
    // a plain letter so the text never closes its line early.
    task automatic send_text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        send_byte(b);
        if (b == CHAR_CR) send_byte(CHAR_X);
    endtask

    task automatic send_size_line(input logic [SIZE_BITS-1:0] size);
        logic [7:0] b;
        bit         after_cr;
        int         n_digits;
        after_cr = 1'b0;
        // leading blanks, including a lone CR (never followed by LF)
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 5))
                    0: b = CHAR_SPACE;
                    1: b = CHAR_TAB;
                    2: b = CHAR_LF;
                    3: b = CHAR_VT;
                    4: b = CHAR_FF;
                    default: b = CHAR_CR;
                endcase
                if (after_cr && b == CHAR_LF) b = CHAR_SPACE;
                after_cr = (b == CHAR_CR);
                send_byte(b);
            end
        end
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_byte("0");
        end
        n_digits = 1;
        while (n_digits < SIZE_BITS / 4 && (size >> (4 * n_digits)) != '0) n_digits++;
        for (int i = n_digits - 1; i >= 0; i--) send_byte(hex_char(int'(size[4*i +: 4])));
        // extension: ';', a blank, or a lone CR, then free text
        if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 2))
                0: send_byte(CHAR_SEMI);
                1: send_byte(CHAR_SPACE);
                default: begin
                    send_byte(CHAR_CR);
                    send_byte(hex_char($urandom_range(0, 15)));
                end
            endcase
            repeat ($urandom_range(0, 6)) send_text_byte();
        end
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    task automatic send_chunk(input int len);
        send_size_line(SIZE_BITS'(len));
        repeat (len) send_byte(8'($urandom_range(0, 255)));
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
        chunks_sent++;
        payload_sent += len;
    endtask

    // Mostly short chunks, a few long ones.
    function automatic int draw_chunk_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 8);
        if (r < 95) return $urandom_range(9, 40);
        return $urandom_range(41, 200);
    endfunction

    // ---------------------------------------------------------------
    // Output side: the receiver stalls for a random gap bounded by MAX_GAP after each word,
    // and honors a long hold-off when a test asks for one.
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (i_out_ready && o_out_valid) stall_left = gaps_on ? $urandom_range(0, MAX_GAP) : 0;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    function automatic void note_mismatch(input string what, input t_decoded want,
                                          input t_decoded got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("Word %0d, %s: expected %02h/%0b/%0b/%0d, got %02h/%0b/%0b/%0d",
                     words_checked, what, want.data_byte, want.data_valid, want.chunk_last,
                     want.status, got.data_byte, got.data_valid, got.chunk_last, got.status);
        end
    endfunction

    // Result checker: every taken word against the oldest prediction.
    always @(posedge i_clk) begin
        t_decoded got;
        t_decoded want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got.data_byte  = o_data_byte;
            got.data_valid = o_data_valid;
            got.chunk_last = o_chunk_last;
            got.status     = t_status'(o_status);
            words_checked++;
            if (predicted_words.size() == 0) begin
                note_mismatch("nothing pending", '0, got);
            end else begin
                want = predicted_words.pop_front();
                if (got.data_byte !== want.data_byte || got.data_valid !== want.data_valid ||
                    got.chunk_last !== want.chunk_last || got.status !== want.status) begin
                    note_mismatch("field differs", want, got);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Opening of the body: all leading blanks and a lone CR before a digit,
    // hex digits inside an extension, a CR ending the digits, payload extremes.
    task automatic test_size_line_cases();
        logic [7:0] seq [24] = '{
            CHAR_SPACE, CHAR_TAB, CHAR_VT, CHAR_FF, CHAR_LF, CHAR_CR,
            "2", CHAR_SEMI, "7", "f", CHAR_CR, CHAR_LF,
            8'h00, 8'hFF, CHAR_CR, CHAR_LF,
            "1", CHAR_CR, "F", CHAR_CR, CHAR_LF,
            8'h80, CHAR_CR, CHAR_LF
        };
        foreach (seq[i]) send_byte(seq[i]);
        chunks_sent  += 2;
        payload_sent += 3;
    endtask

    task automatic test_random_chunks(input int until_bytes);
        while (bytes_sent < until_bytes) send_chunk(draw_chunk_len());
    endtask

    // A stretch with no idling on either side.
    task automatic test_back_to_back(input int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        gaps_on = 1'b0;
        while (bytes_sent < stop_at) send_chunk(draw_chunk_len());
        gaps_on = 1'b1;
    endtask

    // Receiver holds off while the sender keeps offering: the block must stall its input.
    task automatic test_output_hold();
        int stop_at;
        stop_at      = bytes_sent + 60;
        hold_request = HOLD_CYCLES;
        while (bytes_sent < stop_at) send_chunk(draw_chunk_len());
    endtask

    // Closes the body with a terminal case picked at random.
    task automatic test_body_end();
        logic [7:0] b;
        end_kind = t_body_end'($urandom_range(0, 5));
        case (end_kind)
            END_COMPLETE: begin
                send_size_line('0);
                repeat ($urandom_range(0, 3)) begin
                    repeat ($urandom_range(1, 8)) send_text_byte();
                    send_byte(CHAR_CR);
                    send_byte(CHAR_LF);
                end
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            END_NO_DIGITS: begin
                if ($urandom_range(0, 1)) begin
                    send_byte(CHAR_SPACE);
                end else begin
                    send_byte(CHAR_SEMI);
                    send_text_byte();
                end
                send_byte(CHAR_CR);
                send_byte(CHAR_LF);
            end
            END_OVERFLOW: begin
                send_byte(hex_char($urandom_range(1, 15)));
                repeat (SIZE_BITS / 4) send_byte(hex_char($urandom_range(0, 15)));
            end
            END_NO_CR, END_NO_LF: begin
                send_size_line(SIZE_BITS'($urandom_range(1, 4)));
                repeat (size_left) send_byte(8'($urandom_range(0, 255)));
                if (end_kind == END_NO_LF) begin
                    send_byte(CHAR_CR);
                    do b = 8'($urandom_range(0, 255)); while (b == CHAR_LF);
                end else begin
                    do b = 8'($urandom_range(0, 255)); while (b == CHAR_CR);
                end
                send_byte(b);
            end
            default: begin
                // largest size the field holds; payload runs on past the end
                send_size_line('1);
            end
        endcase
    endtask

    // Noise after the end: status must hold (or payload keeps flowing).
    task automatic test_after_end();
        repeat (24) send_byte(8'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        int waited;
        phase_q    = PH_SIZE;
        line_empty = 1'b1;
        clear_size_line();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_size_line_cases();
        test_random_chunks(TARGET_BYTES / 2);
        test_back_to_back(150);
        test_output_hold();
        test_random_chunks(TARGET_BYTES - 60);
        test_body_end();
        test_after_end();
        i_in_valid <= 1'b0;

        waited = 0;
        while (predicted_words.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (SETTLE) @(posedge i_clk);
        if (predicted_words.size() != 0) begin
            $display("%0d result words never arrived", predicted_words.size());
            mismatches += predicted_words.size();
        end

        $display("Sent %0d bytes in %0d chunks (%0d payload), body closed by %s.",
                 bytes_sent, chunks_sent, payload_sent, end_kind.name());
        $display("Checked %0d result words, %0d failed.", words_checked, mismatches);
        if (mismatches == 0) begin
            $display("http_chunked_body_decoder: match");
        end else begin
            $display("http_chunked_body_decoder: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("http_chunked_body_decoder: mismatch");
        $finish;
    end

endmodule
